>>> rtl/dgas_pkg.sv
// dgas_pkg: sizes, request and response words, action and status codes,
// controller states and the command/status groups for the graph store.
// No dependencies; imported by every module of the block.
`default_nettype none

package dgas_pkg;

	// storage sizing
	localparam int MAX_VERTICES = 16;
	localparam int KEY_BITS     = 16;

	localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
	localparam int ECNT_W = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
	localparam int DEG_W  = $clog2(MAX_VERTICES + 1);
	localparam int GONE_W = $clog2(2 * MAX_VERTICES);
	localparam int CMP_W  = (GONE_W > ECNT_W) ? GONE_W : ECNT_W;

	// field widths of the request and response words
	localparam int ACT_W  = 3;
	localparam int VKEY_W = 16;
	localparam int STAT_W = 3;
	localparam int DOUT_W = 5;
	localparam int TDEG_W = 6;
	localparam int VTOT_W = 5;
	localparam int ETOT_W = 9;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD_VERTEX    = 3'd0,
		ACT_REMOVE_VERTEX = 3'd1,
		ACT_ADD_EDGE      = 3'd2,
		ACT_REMOVE_EDGE   = 3'd3,
		ACT_EDGE_QUERY    = 3'd4,
		ACT_DEGREE        = 3'd5,
		ACT_SUMMARY       = 3'd6,
		ACT_NONE          = 3'd7
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_PRESENT   = 3'd2,
		ST_NO_EDGE   = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [VKEY_W-1:0] first_vertex;
		logic [VKEY_W-1:0] second_vertex;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              edge_present;
		logic              is_directed;
		logic [DOUT_W-1:0] in_degree;
		logic [DOUT_W-1:0] out_degree;
		logic [TDEG_W-1:0] total_degree;
		logic [VTOT_W-1:0] vertex_total;
		logic [ETOT_W-1:0] edge_total;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_WALK,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic search_step;
		logic walk_step;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		action_t action;
		logic    idx_last;
		logic    rsp_valid;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/dgas_ctrl.sv
// dgas_ctrl: request sequencer for the graph store (search, walk, commit).
// Depends on dgas_pkg; drives the datapath through dp_cmd_t only.
`default_nettype none

module dgas_ctrl import dgas_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   needs_walk;
	logic   rsp_free;

	// actions that need a pass over the matrix
	always_comb begin
		unique case (stat.action)
			ACT_REMOVE_VERTEX, ACT_DEGREE, ACT_SUMMARY: needs_walk = 1'b1;
			default:                                    needs_walk = 1'b0;
		endcase
	end

	assign rsp_free = !stat.rsp_valid || rsp_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search_step = 1'b1;
				if (stat.idx_last) begin
					state_d = needs_walk ? S_WALK : S_FINISH;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.idx_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (rsp_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// a taken request always starts with the slot search
	a_accept_search: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_SEARCH))
		else $error("accepted request did not start the search");

	// commit only into a free output register
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> rsp_free)
		else $error("commit while output word still held");

	// after a commit the block takes the next request
	a_finish_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> req_ready)
		else $error("not ready after commit");

endmodule

`default_nettype wire

>>> rtl/dgas_dp.sv
// dgas_dp: slot table, adjacency matrix, counters, scan accumulators and
// the output register of the graph store. Depends on dgas_pkg.
`default_nettype none

module dgas_dp import dgas_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_cmd_t  cmd,
	input  logic     rsp_ready,
	output dp_stat_t stat,
	output rsp_t     rsp,
	output logic     rsp_valid
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_VERTICES - 1);

	// request context
	action_t           action_q;
	logic [KEY_BITS-1:0] key_a_q;
	logic [KEY_BITS-1:0] key_b_q;

	// scan state
	logic [IDX_W-1:0]  idx_q;
	logic              a_hit_q;
	logic              b_hit_q;
	logic              free_hit_q;
	logic [IDX_W-1:0]  a_idx_q;
	logic [IDX_W-1:0]  b_idx_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [DEG_W-1:0]  in_acc_q;
	logic [DEG_W-1:0]  out_acc_q;
	logic [GONE_W-1:0] gone_q;
	logic              dir_q;

	// graph state
	logic [MAX_VERTICES-1:0] slot_valid_q;
	logic [KEY_BITS-1:0]     slot_key_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
	logic [VCNT_W-1:0]       vcount_q;
	logic [ECNT_W-1:0]       ecount_q;

	// output register
	rsp_t rsp_q;
	logic rsp_valid_q;

	// combinational
	logic                    idx_last;
	logic [KEY_BITS-1:0]     rd_key;
	logic                    rd_valid;
	logic                    hit_a;
	logic                    hit_b;
	logic [MAX_VERTICES-1:0] row_j;
	logic [MAX_VERTICES-1:0] col_j;
	logic                    a_to_j;
	logic                    j_to_a;
	logic                    sym_miss;
	logic [MAX_VERTICES-1:0] valid_d;
	logic [MAX_VERTICES-1:0] adj_d [MAX_VERTICES];
	logic [VCNT_W-1:0]       vcount_d;
	logic [ECNT_W-1:0]       ecount_d;
	logic                    key_we;
	logic                    edge_ab;
	logic                    present;
	status_t                 st;
	logic [CMP_W-1:0]        gone_ext;
	logic [CMP_W-1:0]        ecount_ext;
	logic [DEG_W:0]          deg_sum;
	rsp_t                    rsp_d;
	logic                    orphan;

	assign idx_last = (idx_q == IDX_LAST);

	// slot read and key compare at the scan index
	assign rd_key   = slot_key_q[idx_q];
	assign rd_valid = slot_valid_q[idx_q];
	assign hit_a    = rd_valid && (rd_key == key_a_q);
	assign hit_b    = rd_valid && (rd_key == key_b_q);

	// row and column of the walked vertex
	assign row_j = adj_q[idx_q];
	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			col_j[i] = adj_q[i][idx_q];
		end
	end
	assign a_to_j   = adj_q[a_idx_q][idx_q];
	assign j_to_a   = row_j[a_idx_q];
	assign sym_miss = |(row_j & ~col_j);

	// request capture and scan registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q   <= action_t'(req.action);
			key_a_q    <= KEY_BITS'(req.first_vertex);
			key_b_q    <= KEY_BITS'(req.second_vertex);
			idx_q      <= '0;
			a_hit_q    <= 1'b0;
			b_hit_q    <= 1'b0;
			free_hit_q <= 1'b0;
			a_idx_q    <= '0;
			b_idx_q    <= '0;
			free_idx_q <= '0;
			in_acc_q   <= '0;
			out_acc_q  <= '0;
			gone_q     <= '0;
			dir_q      <= 1'b0;
		end else begin
			if (cmd.search_step || cmd.walk_step) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			// slot search: keys are unique, lowest free slot wins
			if (cmd.search_step) begin
				if (hit_a) begin
					a_hit_q <= 1'b1;
					a_idx_q <= idx_q;
				end
				if (hit_b) begin
					b_hit_q <= 1'b1;
					b_idx_q <= idx_q;
				end
				if (!rd_valid && !free_hit_q) begin
					free_hit_q <= 1'b1;
					free_idx_q <= idx_q;
				end
			end
			// matrix walk: degrees, edges lost on removal, symmetry
			if (cmd.walk_step) begin
				out_acc_q <= out_acc_q + DEG_W'(a_to_j);
				in_acc_q  <= in_acc_q + DEG_W'(rd_valid && j_to_a);
				gone_q    <= gone_q + GONE_W'(a_to_j)
					+ GONE_W'((idx_q != a_idx_q) && j_to_a);
				dir_q     <= dir_q | sym_miss;
			end
		end
	end

	// commit: state update and result word
	always_comb begin
		valid_d    = slot_valid_q;
		adj_d      = adj_q;
		vcount_d   = vcount_q;
		ecount_d   = ecount_q;
		key_we     = 1'b0;
		st         = ST_OK;
		present    = 1'b0;
		edge_ab    = adj_q[a_idx_q][b_idx_q];
		gone_ext   = CMP_W'(gone_q);
		ecount_ext = CMP_W'(ecount_q);
		unique case (action_q)
			ACT_ADD_VERTEX: begin
				if (a_hit_q) begin
					st = ST_PRESENT;
				end else if (!free_hit_q) begin
					st = ST_FULL;
				end else begin
					valid_d[free_idx_q] = 1'b1;
					key_we              = 1'b1;
					for (int i = 0; i < MAX_VERTICES; i++) begin
						adj_d[i][free_idx_q] = 1'b0;
					end
					adj_d[free_idx_q] = '0;
					vcount_d          = vcount_q + 1'b1;
				end
			end
			ACT_REMOVE_VERTEX: begin
				if (!a_hit_q) begin
					st = ST_NOT_FOUND;
				end else begin
					for (int i = 0; i < MAX_VERTICES; i++) begin
						adj_d[i][a_idx_q] = 1'b0;
					end
					adj_d[a_idx_q]   = '0;
					valid_d[a_idx_q] = 1'b0;
					vcount_d         = vcount_q - 1'b1;
					ecount_d         = (gone_ext <= ecount_ext)
						? ECNT_W'(ecount_ext - gone_ext) : '0;
				end
			end
			ACT_ADD_EDGE: begin
				if (!a_hit_q || !b_hit_q) begin
					st = ST_NOT_FOUND;
				end else if (edge_ab) begin
					st = ST_PRESENT;
				end else begin
					adj_d[a_idx_q][b_idx_q] = 1'b1;
					ecount_d                = ecount_q + 1'b1;
				end
			end
			ACT_REMOVE_EDGE: begin
				if (!a_hit_q || !b_hit_q) begin
					st = ST_NOT_FOUND;
				end else if (!edge_ab) begin
					st = ST_NO_EDGE;
				end else begin
					adj_d[a_idx_q][b_idx_q] = 1'b0;
					ecount_d                = ecount_q - 1'b1;
				end
			end
			ACT_EDGE_QUERY: begin
				if (!a_hit_q || !b_hit_q) begin
					st = ST_NOT_FOUND;
				end else begin
					present = edge_ab;
				end
			end
			ACT_DEGREE: begin
				if (!a_hit_q) begin
					st = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase

		deg_sum            = {1'b0, in_acc_q} + {1'b0, out_acc_q};
		rsp_d              = '0;
		rsp_d.status       = st;
		rsp_d.edge_present = present;
		rsp_d.is_directed  = (action_q == ACT_SUMMARY) && dir_q;
		if (action_q == ACT_DEGREE && st == ST_OK) begin
			rsp_d.in_degree    = DOUT_W'(in_acc_q);
			rsp_d.out_degree   = DOUT_W'(out_acc_q);
			rsp_d.total_degree = TDEG_W'(deg_sum);
		end
		rsp_d.vertex_total = VTOT_W'(vcount_d);
		rsp_d.edge_total   = ETOT_W'(ecount_d);
	end

	// graph state with reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			vcount_q     <= '0;
			ecount_q     <= '0;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.finish) begin
			slot_valid_q <= valid_d;
			vcount_q     <= vcount_d;
			ecount_q     <= ecount_d;
			adj_q        <= adj_d;
		end
	end

	// key table, written on vertex add
	always_ff @(posedge clk) begin
		if (cmd.finish && key_we) begin
			slot_key_q[free_idx_q] <= key_a_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign stat.action    = action_q;
	assign stat.idx_last  = idx_last;
	assign stat.rsp_valid = rsp_valid_q;

	// edges touching an empty slot
	always_comb begin
		orphan = 1'b0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (!slot_valid_q[i] && (adj_q[i] != '0)) begin
				orphan = 1'b1;
			end
			if ((adj_q[i] & ~slot_valid_q) != '0) begin
				orphan = 1'b1;
			end
		end
	end

	// vertex count tracks the occupied slots
	a_vcount: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q == VCNT_W'($countones(slot_valid_q)))
		else $error("vertex count differs from occupied slots");

	// no edge may start or end at an empty slot
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		!orphan)
		else $error("edge attached to an empty slot");

	// a new result word only appears after a commit
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.finish))
		else $error("result word without commit");

endmodule

`default_nettype wire

>>> rtl/directed_graph_adjacency_store.sv
// directed_graph_adjacency_store: top level of the directed graph store.
// Depends on dgas_pkg, dgas_ctrl and dgas_dp.
//
// Each request word (action, first and second vertex key) gives exactly one
// result word. A request is taken when the block is idle, then the 16 key
// slots are searched one per cycle through the single slot read port. Add
// vertex, the edge actions and the unused action then commit the result;
// remove vertex, degree and summary first walk the adjacency matrix one row
// and column per cycle, then commit. The result sits in an output register,
// so the next request is taken and searched while the previous result waits;
// the commit waits for that register to drain. The matrix and slot flags
// clear at reset, so the block takes requests straight after reset with no
// clearing pass.
`default_nettype none

module directed_graph_adjacency_store import dgas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	dgas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and result datapath
	dgas_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

endmodule

`default_nettype wire

>>> test/tb_directed_graph_adjacency_store.sv
`timescale 1ns / 100ps
// tb_directed_graph_adjacency_store: self-checking bench for the directed graph store.
// Keeps its own copy of the graph and checks every result word in order.
// Depends on dgas_pkg and directed_graph_adjacency_store.

module tb_directed_graph_adjacency_store;
	import dgas_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int POOL_SIZE = 20;
	localparam int RANDOM_WORDS = 800;
	localparam int HOLD_CYCLES = 600;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	typedef struct {
		req_t w;
		int   reps;
		bit   typed;
		rsp_t want;
	} script_row_t;

	// shadow copy of the graph
	bit                      live [MAX_VERTICES];
	logic [KEY_BITS-1:0]     vertex_key [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] arc_row [MAX_VERTICES];
	int                      live_count;
	int                      arc_count;

	rsp_t                awaited_answers [$];
	logic [VKEY_W-1:0]   key_pool [POOL_SIZE];
	int                  mismatches = 0;
	int unsigned         cycles = 0;

	directed_graph_adjacency_store dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	function automatic int find_vertex(logic [VKEY_W-1:0] k);
		for (int i = 0; i < MAX_VERTICES; i++)
			if (live[i] && vertex_key[i] == k[KEY_BITS-1:0])
				return i;
		return -1;
	endfunction

	// apply one request to the shadow graph and work out its result word
	function automatic rsp_t graph_apply(req_t w);
		rsp_t r;
		int a, b, slot, gone, ind, outd;
		bit hit, dir;
		r = '0;
		ind = 0;
		outd = 0;
		dir = 1'b0;
		hit = 1'b0;
		a = find_vertex(w.first_vertex);
		b = find_vertex(w.second_vertex);
		case (action_t'(w.action))
			ACT_ADD_VERTEX: begin
				slot = -1;
				for (int i = MAX_VERTICES - 1; i >= 0; i--)
					if (!live[i])
						slot = i;
				if (a >= 0)
					r.status = ST_PRESENT;
				else if (slot < 0)
					r.status = ST_FULL;
				else begin
					live[slot] = 1'b1;
					vertex_key[slot] = w.first_vertex[KEY_BITS-1:0];
					arc_row[slot] = '0;
					for (int j = 0; j < MAX_VERTICES; j++)
						arc_row[j][slot] = 1'b0;
					live_count++;
				end
			end
			ACT_REMOVE_VERTEX: begin
				if (a < 0)
					r.status = ST_NOT_FOUND;
				else begin
					// row and column go together, a self loop counted once
					gone = $countones(arc_row[a]);
					for (int j = 0; j < MAX_VERTICES; j++) begin
						if (j != a && arc_row[j][a])
							gone++;
						arc_row[j][a] = 1'b0;
					end
					arc_row[a] = '0;
					arc_count = (gone <= arc_count) ? arc_count - gone : 0;
					live[a] = 1'b0;
					live_count--;
				end
			end
			ACT_ADD_EDGE, ACT_REMOVE_EDGE, ACT_EDGE_QUERY: begin
				if (a < 0 || b < 0)
					r.status = ST_NOT_FOUND;
				else begin
					hit = arc_row[a][b];
					if (action_t'(w.action) == ACT_ADD_EDGE) begin
						if (hit)
							r.status = ST_PRESENT;
						else begin
							arc_row[a][b] = 1'b1;
							arc_count++;
						end
						hit = 1'b0;
					end else if (action_t'(w.action) == ACT_REMOVE_EDGE) begin
						if (!hit)
							r.status = ST_NO_EDGE;
						else begin
							arc_row[a][b] = 1'b0;
							arc_count--;
						end
						hit = 1'b0;
					end
				end
			end
			ACT_DEGREE: begin
				if (a < 0)
					r.status = ST_NOT_FOUND;
				else begin
					outd = $countones(arc_row[a]);
					for (int j = 0; j < MAX_VERTICES; j++)
						if (live[j] && arc_row[j][a])
							ind++;
				end
			end
			ACT_SUMMARY: begin
				for (int i = 0; i < MAX_VERTICES; i++)
					for (int j = 0; j < MAX_VERTICES; j++)
						if (arc_row[i][j] && !arc_row[j][i])
							dir = 1'b1;
			end
			default: ;
		endcase
		r.edge_present = hit;
		r.is_directed = dir;
		r.in_degree = DOUT_W'(ind);
		r.out_degree = DOUT_W'(outd);
		r.total_degree = TDEG_W'(ind + outd);
		r.vertex_total = VTOT_W'(live_count);
		r.edge_total = ETOT_W'(arc_count);
		return r;
	endfunction

	function automatic rsp_t answer(status_t st, bit ep, bit dir, int ind, int outd,
			int vt, int et);
		rsp_t r;
		r.status = st;
		r.edge_present = ep;
		r.is_directed = dir;
		r.in_degree = DOUT_W'(ind);
		r.out_degree = DOUT_W'(outd);
		r.total_degree = TDEG_W'(ind + outd);
		r.vertex_total = VTOT_W'(vt);
		r.edge_total = ETOT_W'(et);
		return r;
	endfunction

	function automatic script_row_t script_line(action_t act, logic [VKEY_W-1:0] k1,
			logic [VKEY_W-1:0] k2, int reps, bit typed, rsp_t want);
		script_row_t s;
		s.w.action = act;
		s.w.first_vertex = k1;
		s.w.second_vertex = k2;
		s.reps = reps;
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	function automatic string show(rsp_t r);
		return $sformatf("st=%0d ep=%0d dir=%0d in=%0d out=%0d tot=%0d vt=%0d et=%0d",
			r.status, r.edge_present, r.is_directed, r.in_degree, r.out_degree,
			r.total_degree, r.vertex_total, r.edge_total);
	endfunction

	// gap length: mostly none or short, a few long, with quiet stretches
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if ((cycles / 700) % 4 == 1)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(15, 4);
		return $urandom_range(90, 20);
	endfunction

	// a key that is mostly stored when asked for, else from the pool or anywhere
	function automatic logic [VKEY_W-1:0] pick_key(bit present);
		int stored [$];
		for (int i = 0; i < MAX_VERTICES; i++)
			if (live[i])
				stored.push_back(i);
		if (present && stored.size() != 0 && $urandom_range(99) < 85)
			return vertex_key[stored[$urandom_range(stored.size() - 1)]];
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return VKEY_W'($urandom_range(16'hFFFF));
	endfunction

	// offer one request word and hold it until taken
	task automatic offer_word(input req_t w, input bit typed, input rsp_t want);
		rsp_t predicted;
		int gap;
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		predicted = graph_apply(w);
		awaited_answers.push_back(typed ? want : predicted);
		gap = idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[directed_graph_adjacency_store] ERROR");
			$finish;
		end
	end

	// result side: check each taken word, then decide the next ready
	initial begin
		int hold_left;
		int stall_left;
		int words_seen;
		rsp_t want;
		bit bad;
		hold_left = 0;
		stall_left = 0;
		words_seen = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
				if (awaited_answers.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word: %s", show(rsp));
					mismatches++;
				end else begin
					want = awaited_answers.pop_front();
					bad = (rsp.status !== want.status) ||
						(rsp.edge_present !== want.edge_present) ||
						(rsp.is_directed !== want.is_directed) ||
						(rsp.in_degree !== want.in_degree) ||
						(rsp.out_degree !== want.out_degree) ||
						(rsp.total_degree !== want.total_degree) ||
						(rsp.vertex_total !== want.vertex_total) ||
						(rsp.edge_total !== want.edge_total);
					if (bad) begin
						if (mismatches < 10)
							$display("mismatch on word %0d: got %s, expected %s",
								words_seen, show(rsp), show(want));
						mismatches++;
					end
				end
				words_seen++;
				// long hold-off so the block fills and stalls its input
				if (words_seen == 40 || words_seen == 450)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				stall_left = idle_len();
				rsp_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// stimulus
	initial begin
		script_row_t script [$];
		script_row_t s;
		req_t w;
		action_t act;
		logic [VKEY_W-1:0] tmp;
		logic [VKEY_W-1:0] doomed [$];
		int unsigned cut [4][7];
		int n, phase, last_phase, pick;

		for (int i = 0; i < MAX_VERTICES; i++) begin
			live[i] = 1'b0;
			vertex_key[i] = '0;
			arc_row[i] = '0;
		end
		live_count = 0;
		arc_count = 0;
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = VKEY_W'($urandom_range(16'hFFFF));

		// cumulative action weights: plain, symmetric, dense, churn
		cut[0] = '{20, 28, 58, 70, 82, 92, 98};
		cut[1] = '{15, 20, 55, 65, 77, 89, 99};
		cut[2] = '{20, 22, 72, 76, 84, 94, 99};
		cut[3] = '{20, 55, 70, 80, 86, 94, 99};

		// directed part
		script.push_back(script_line(ACT_SUMMARY, 16'h0000, 16'h0000, 1, 1,
			answer(ST_OK, 0, 0, 0, 0, 0, 0)));
		script.push_back(script_line(ACT_REMOVE_VERTEX, 16'h0000, 16'h0000, 1, 1,
			answer(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0)));
		script.push_back(script_line(ACT_DEGREE, 16'h1234, 16'hFFFF, 1, 1,
			answer(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0)));
		script.push_back(script_line(ACT_NONE, 16'hFFFF, 16'hFFFF, 1, 1,
			answer(ST_OK, 0, 0, 0, 0, 0, 0)));
		script.push_back(script_line(ACT_ADD_VERTEX, 16'h0000, 16'hFFFF, 1, 1,
			answer(ST_OK, 0, 0, 0, 0, 1, 0)));
		script.push_back(script_line(ACT_ADD_VERTEX, 16'h0000, 16'h0000, 1, 1,
			answer(ST_PRESENT, 0, 0, 0, 0, 1, 0)));
		script.push_back(script_line(ACT_ADD_VERTEX, 16'hFFFF, 16'h0000, 1, 1,
			answer(ST_OK, 0, 0, 0, 0, 2, 0)));
		script.push_back(script_line(ACT_ADD_EDGE, 16'h0000, 16'hFFFF, 1, 1,
			answer(ST_OK, 0, 0, 0, 0, 2, 1)));
		script.push_back(script_line(ACT_ADD_EDGE, 16'h0000, 16'hFFFF, 1, 1,
			answer(ST_PRESENT, 0, 0, 0, 0, 2, 1)));
		script.push_back(script_line(ACT_ADD_EDGE, 16'h0000, 16'h1234, 1, 1,
			answer(ST_NOT_FOUND, 0, 0, 0, 0, 2, 1)));
		script.push_back(script_line(ACT_SUMMARY, 16'h0000, 16'h0000, 1, 1,
			answer(ST_OK, 0, 1, 0, 0, 2, 1)));
		script.push_back(script_line(ACT_ADD_EDGE, 16'hFFFF, 16'hFFFF, 1, 0, '0));
		script.push_back(script_line(ACT_ADD_EDGE, 16'hFFFF, 16'h0000, 1, 0, '0));
		script.push_back(script_line(ACT_SUMMARY, 16'hFFFF, 16'hFFFF, 1, 1,
			answer(ST_OK, 0, 0, 0, 0, 2, 3)));
		script.push_back(script_line(ACT_EDGE_QUERY, 16'hFFFF, 16'h0000, 1, 0, '0));
		script.push_back(script_line(ACT_DEGREE, 16'hFFFF, 16'h0000, 1, 0, '0));
		script.push_back(script_line(ACT_REMOVE_EDGE, 16'h0000, 16'h0000, 1, 1,
			answer(ST_NO_EDGE, 0, 0, 0, 0, 2, 3)));
		script.push_back(script_line(ACT_REMOVE_EDGE, 16'h0000, 16'hFFFF, 1, 0, '0));
		script.push_back(script_line(ACT_REMOVE_VERTEX, 16'hFFFF, 16'h0000, 1, 0, '0));
		script.push_back(script_line(ACT_ADD_VERTEX, 16'h8000, 16'h0000, 15, 0, '0));
		script.push_back(script_line(ACT_ADD_VERTEX, 16'h7FFF, 16'h0000, 1, 1,
			answer(ST_FULL, 0, 0, 0, 0, 16, 0)));
		script.push_back(script_line(ACT_REMOVE_VERTEX, 16'h0000, 16'h0000, 1, 0, '0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (script[r]) begin
			s = script[r];
			for (int k = 0; k < s.reps; k++) begin
				w = s.w;
				w.first_vertex = VKEY_W'(s.w.first_vertex + k);
				offer_word(w, s.typed, s.want);
			end
		end

		// random part in phases of a hundred words
		n = 0;
		last_phase = -1;
		while (n < RANDOM_WORDS) begin
			phase = (n / 100) % 4;
			// symmetric phase starts from an empty graph so summaries can clear
			if (phase == 1 && last_phase != 1) begin
				doomed.delete();
				for (int i = 0; i < MAX_VERTICES; i++)
					if (live[i])
						doomed.push_back(vertex_key[i]);
				foreach (doomed[d]) begin
					w.action = ACT_REMOVE_VERTEX;
					w.first_vertex = doomed[d];
					w.second_vertex = VKEY_W'($urandom_range(16'hFFFF));
					offer_word(w, 1'b0, '0);
					n++;
				end
			end
			last_phase = phase;

			pick = $urandom_range(99);
			act = ACT_NONE;
			for (int i = 6; i >= 0; i--)
				if (pick < cut[phase][i])
					act = action_t'(i);
			w.action = act;
			w.first_vertex = VKEY_W'($urandom_range(16'hFFFF));
			w.second_vertex = VKEY_W'($urandom_range(16'hFFFF));
			case (act)
				ACT_ADD_VERTEX: w.first_vertex = pick_key(1'b0);
				ACT_REMOVE_VERTEX, ACT_DEGREE: w.first_vertex = pick_key(1'b1);
				ACT_ADD_EDGE, ACT_REMOVE_EDGE, ACT_EDGE_QUERY: begin
					w.first_vertex = pick_key(1'b1);
					w.second_vertex = pick_key(1'b1);
				end
				default: ;
			endcase
			offer_word(w, 1'b0, '0);
			n++;

			// mirror every edge change while the graph is kept symmetric
			if (phase == 1 && (act == ACT_ADD_EDGE || act == ACT_REMOVE_EDGE)) begin
				tmp = w.first_vertex;
				w.first_vertex = w.second_vertex;
				w.second_vertex = tmp;
				offer_word(w, 1'b0, '0);
				n++;
			end
		end
		req_valid <= 1'b0;

		// drain, then allow for a late stray word
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("[directed_graph_adjacency_store] OK");
		else
			$display("[directed_graph_adjacency_store] ERROR");
		$finish;
	end

endmodule
